>>> rtl/ultrasonic_echo_ranger_macros.svh
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger assertion macros
// Shared assertion shorthands. Each one samples on clk_i and is disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// Same-cycle implication.
`define UER_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Types, register map and reset values shared by the ranger modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uer_pkg;

  // Field widths.
  localparam int PeriodW  = 26;
  localparam int TrigW    = 8;
  localparam int TimeoutW = 20;
  localparam int DivisorW = 16;
  localparam int RawW     = 20;

  // Divider runs one quotient bit per cycle.
  localparam int DivSteps = RawW;
  localparam int DivCntW  = $clog2(DivSteps);

  // Stream payload widths.
  localparam int InDataW  = 8;
  localparam int OutDataW = 48;

  // Configuration port.
  localparam int AddrW = 5;
  localparam int IdxW  = 3;

  localparam logic [IdxW-1:0] REG_PERIOD    = 3'd0;
  localparam logic [IdxW-1:0] REG_TRIGGER   = 3'd1;
  localparam logic [IdxW-1:0] REG_START_TO  = 3'd2;
  localparam logic [IdxW-1:0] REG_WIDTH_TO  = 3'd3;
  localparam logic [IdxW-1:0] REG_DIVISOR   = 3'd4;

  localparam logic [PeriodW-1:0]  RST_PERIOD   = 26'd500000;
  localparam logic [TrigW-1:0]    RST_TRIGGER  = 8'd20;
  localparam logic [TimeoutW-1:0] RST_START_TO = 20'd25000;
  localparam logic [TimeoutW-1:0] RST_WIDTH_TO = 20'd100000;
  localparam logic [DivisorW-1:0] RST_DIVISOR  = 16'd450;

  // Measurement phase of the ranging sequence.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_HIGH = 2'd3
  } phase_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_PUSH = 2'd2
  } ctrl_state_e;

  // Register file contents.
  typedef struct packed {
    logic [PeriodW-1:0]  period;
    logic [TrigW-1:0]    trigger;
    logic [TimeoutW-1:0] start_to;
    logic [TimeoutW-1:0] width_to;
    logic [DivisorW-1:0] divisor;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic step;      // apply one tick to the ranging state
    logic div_step;  // one divider iteration
    logic push;      // load the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_need;  // the offered tick ends a good echo
    logic div_last;  // the current divider iteration is the final one
    logic out_free;  // output register can take a new beat
  } sts_t;

endpackage

>>> rtl/uer_ctrl.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger controller
// Sequences input acceptance, the serial divide and the output load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_macros.svh"

module uer_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  uer_pkg::sts_t sts_i,
  output uer_pkg::cmd_t cmd_o
);

  uer_pkg::ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= uer_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      uer_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.div_need ? uer_pkg::ST_DIV : uer_pkg::ST_PUSH;
        end
      end
      uer_pkg::ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = uer_pkg::ST_PUSH;
        end
      end
      uer_pkg::ST_PUSH: begin
        if (sts_i.out_free) begin
          state_d = uer_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = uer_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    unique case (state_q)
      uer_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.step = in_valid_i;
      end
      uer_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      uer_pkg::ST_PUSH: begin
        cmd_o.push = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // A good echo always runs the divider before its beat is loaded.
  `UER_ASSERT_NEXT(a_good_echo_divides, cmd_o.step && sts_i.div_need,
                   state_q == uer_pkg::ST_DIV, "good echo did not start divide")

  // The last divider iteration hands over to the output load.
  `UER_ASSERT_NEXT(a_div_to_push, state_q == uer_pkg::ST_DIV && sts_i.div_last,
                   state_q == uer_pkg::ST_PUSH, "divide did not end in push")

endmodule

>>> rtl/uer_dp.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger datapath
// Tick counter, phase register, stored results, restoring divider and the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_macros.svh"

module uer_dp #(
  parameter int CounterWidth = 26
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  uer_pkg::cfg_t                  cfg_i,
  input  logic                           echo_i,
  input  uer_pkg::cmd_t                  cmd_i,
  output uer_pkg::sts_t                  sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [uer_pkg::OutDataW-1:0]   out_data_o
);

  localparam int CmpW = (CounterWidth + 1 > uer_pkg::PeriodW) ?
                        CounterWidth + 1 : uer_pkg::PeriodW;
  localparam int PadW = uer_pkg::OutDataW - 4 - 2 * uer_pkg::RawW;

  uer_pkg::phase_e                    phase_q, phase_d;
  logic [CounterWidth-1:0]            tick_q, tick_d;
  logic [uer_pkg::RawW-1:0]           raw_q, raw_d;
  logic [uer_pkg::RawW-1:0]           cm_q;
  logic                               err_q, err_d;
  logic                               pend_drive_q, pend_drive_d;
  logic                               pend_ready_q, pend_ready_d;
  logic                               finish;
  logic                               good;

  logic [CmpW-1:0]                    next_w;
  logic [CounterWidth-1:0]            next_m;

  logic [uer_pkg::DivisorW-1:0]       rem_q;
  logic [uer_pkg::RawW-1:0]           quo_q;
  logic [uer_pkg::DivCntW-1:0]        div_cnt_q;
  logic [uer_pkg::DivisorW:0]         rem_sh;
  logic [uer_pkg::DivisorW+1:0]       trial;
  logic [uer_pkg::DivisorW-1:0]       rem_n;
  logic [uer_pkg::RawW-1:0]           quo_n;

  logic                               out_valid_q;
  logic [uer_pkg::OutDataW-1:0]       out_data_q;

  assign next_w = CmpW'(tick_q) + CmpW'(1);
  assign next_m = next_w[CounterWidth-1:0];

  // One tick of the ranging sequence.
  always_comb begin
    phase_d      = phase_q;
    tick_d       = tick_q;
    finish       = 1'b0;
    good         = 1'b0;
    pend_drive_d = 1'b0;
    unique case (phase_q)
      uer_pkg::PH_IDLE: begin
        if (next_w >= CmpW'(cfg_i.period) || (&tick_q)) begin
          phase_d = uer_pkg::PH_TRIG;
          tick_d  = '0;
        end else begin
          tick_d  = next_m;
        end
      end
      uer_pkg::PH_TRIG: begin
        pend_drive_d = 1'b1;
        if (next_w >= CmpW'(cfg_i.trigger)) begin
          phase_d = uer_pkg::PH_WAIT;
          tick_d  = '0;
        end else begin
          tick_d  = next_m;
        end
      end
      uer_pkg::PH_WAIT: begin
        if (echo_i && CmpW'(tick_q) < CmpW'(cfg_i.start_to)) begin
          // The rising tick counts as the first high tick.
          phase_d = uer_pkg::PH_HIGH;
          tick_d  = CounterWidth'(1);
          finish  = (cfg_i.width_to <= uer_pkg::TimeoutW'(1));
        end else begin
          tick_d  = next_m;
          finish  = (CmpW'(next_m) >= CmpW'(cfg_i.start_to));
        end
      end
      uer_pkg::PH_HIGH: begin
        if (echo_i) begin
          tick_d = next_m;
          finish = (CmpW'(next_m) >= CmpW'(cfg_i.width_to));
        end else begin
          finish = 1'b1;
          good   = 1'b1;
        end
      end
      default: begin
        phase_d = uer_pkg::PH_IDLE;
      end
    endcase
    if (finish) begin
      phase_d = uer_pkg::PH_IDLE;
      tick_d  = '0;
    end
  end

  // Result bookkeeping on a finished measurement.
  assign raw_d        = good ? tick_q[uer_pkg::RawW-1:0] : raw_q;
  assign err_d        = finish ? !good : err_q;
  assign pend_ready_d = finish;

  // Restoring divide step; a zero divisor yields all ones.
  assign rem_sh = {rem_q, quo_q[uer_pkg::RawW-1]};
  assign trial  = {1'b0, rem_sh} - (uer_pkg::DivisorW + 2)'(cfg_i.divisor);
  always_comb begin
    if (!trial[uer_pkg::DivisorW+1]) begin
      rem_n = trial[uer_pkg::DivisorW-1:0];
      quo_n = {quo_q[uer_pkg::RawW-2:0], 1'b1};
    end else begin
      rem_n = rem_sh[uer_pkg::DivisorW-1:0];
      quo_n = {quo_q[uer_pkg::RawW-2:0], 1'b0};
    end
  end

  // Ranging state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= uer_pkg::PH_IDLE;
      tick_q       <= '0;
      raw_q        <= '0;
      err_q        <= 1'b0;
      pend_drive_q <= 1'b0;
      pend_ready_q <= 1'b0;
    end else if (cmd_i.step) begin
      phase_q      <= phase_d;
      tick_q       <= tick_d;
      raw_q        <= raw_d;
      err_q        <= err_d;
      pend_drive_q <= pend_drive_d;
      pend_ready_q <= pend_ready_d;
    end
  end

  // Divider registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
      cm_q      <= '0;
    end else if (cmd_i.step && good) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + uer_pkg::DivCntW'(1);
      if (div_cnt_q == uer_pkg::DivCntW'(uer_pkg::DivSteps - 1)) begin
        cm_q <= quo_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && good) begin
      rem_q <= '0;
      quo_q <= tick_q[uer_pkg::RawW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_data_q <= {{PadW{1'b0}}, pend_ready_q, err_q, cm_q, raw_q,
                     pend_drive_q, pend_drive_q};
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign sts_o.div_need  = good;
  assign sts_o.div_last  = (div_cnt_q == uer_pkg::DivCntW'(uer_pkg::DivSteps - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // A tick cannot both drive the trigger and finish a measurement.
  `UER_ASSERT_NOW(a_drive_excl_ready, 1'b1, !(pend_drive_q && pend_ready_q),
                  "trigger drive and result strobe together")

  // A finished measurement returns to idle with a cleared count.
  `UER_ASSERT_NEXT(a_finish_idle, cmd_i.step && finish,
                   phase_q == uer_pkg::PH_IDLE && tick_q == '0,
                   "measurement end did not return to idle")

endmodule

>>> rtl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Periodic trigger and echo-width timer for a single-wire ranging sensor.
// ----------------------------------------------------------------------------
// Each input beat is one time-base tick with the sampled echo line and yields
// exactly one output beat. A tick is accepted and then loaded into the output
// register; on a tick that ends a good echo a restoring divider runs between
// them, producing one centimeter quotient bit per cycle. A finished beat waits
// in the output register while the next tick is already taken. Registers sit
// at byte addresses 0x00 period, 0x04 trigger length, 0x08 start timeout,
// 0x0C width timeout, 0x10 centimeter divisor. The user must see that they are
// written only while no tick is in flight; the block itself does not enforce it.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger #(
  parameter int COUNTER_WIDTH = 26
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input tick stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [uer_pkg::InDataW-1:0]   s_axis_tdata,   // [0] echo_level
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] drive_enable, [1] drive_level, [21:2] range_raw, [41:22] range_cm,
  // [42] sensor_error, [43] result_ready, upper bits zero
  output logic [uer_pkg::OutDataW-1:0]  m_axis_tdata,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uer_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  uer_pkg::cfg_t              cfg_q;
  uer_pkg::cmd_t              cmd;
  uer_pkg::sts_t              sts;
  logic                       wr_en;
  logic [uer_pkg::IdxW-1:0]   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[uer_pkg::AddrW-1:2];

  // Register file writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period   <= uer_pkg::RST_PERIOD;
      cfg_q.trigger  <= uer_pkg::RST_TRIGGER;
      cfg_q.start_to <= uer_pkg::RST_START_TO;
      cfg_q.width_to <= uer_pkg::RST_WIDTH_TO;
      cfg_q.divisor  <= uer_pkg::RST_DIVISOR;
    end else if (wr_en) begin
      unique case (reg_idx)
        uer_pkg::REG_PERIOD:   cfg_q.period   <= pwdata[uer_pkg::PeriodW-1:0];
        uer_pkg::REG_TRIGGER:  cfg_q.trigger  <= pwdata[uer_pkg::TrigW-1:0];
        uer_pkg::REG_START_TO: cfg_q.start_to <= pwdata[uer_pkg::TimeoutW-1:0];
        uer_pkg::REG_WIDTH_TO: cfg_q.width_to <= pwdata[uer_pkg::TimeoutW-1:0];
        uer_pkg::REG_DIVISOR:  cfg_q.divisor  <= pwdata[uer_pkg::DivisorW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      uer_pkg::REG_PERIOD:   prdata = 32'(cfg_q.period);
      uer_pkg::REG_TRIGGER:  prdata = 32'(cfg_q.trigger);
      uer_pkg::REG_START_TO: prdata = 32'(cfg_q.start_to);
      uer_pkg::REG_WIDTH_TO: prdata = 32'(cfg_q.width_to);
      uer_pkg::REG_DIVISOR:  prdata = 32'(cfg_q.divisor);
      default:               prdata = '0;
    endcase
  end

  uer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  uer_dp #(
    .CounterWidth (COUNTER_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .echo_i      (s_axis_tdata[0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
